/* rtl/core/kss_pkg.sv */
package kss_pkg;

  localparam int ALPHABET_SIZE_DEFAULT = 26;
  localparam logic [7:0] FIRST_LETTER = 8'd65;
  localparam int DIST_W = 5;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_ENCODE = 2'd2;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_LOAD_D,
    OP_REDUCE_D,
    OP_CALC_K,
    OP_SET_M,
    OP_READ_KW,
    OP_SCAN,
    OP_EMIT_LETTER,
    OP_EMIT_BYTE
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NSTART,
    C_CMD_CLEAR,
    C_CMD_KEY,
    C_CMD_ENCODE,
    C_D_GE,
    C_NOT_LETTER,
    C_K_GE,
    C_NOT_FOUND
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_DIS_CLR  = 4'd1;
  localparam step_t ST_DIS_KEY  = 4'd2;
  localparam step_t ST_DIS_ENC  = 4'd3;
  localparam step_t ST_DROP     = 4'd4;
  localparam step_t ST_CLEAR    = 4'd5;
  localparam step_t ST_APPEND   = 4'd6;
  localparam step_t ST_LOAD_D   = 4'd7;
  localparam step_t ST_REDUCE_D = 4'd8;
  localparam step_t ST_CHK_LTR  = 4'd9;
  localparam step_t ST_CALC_K   = 4'd10;
  localparam step_t ST_SET_M    = 4'd11;
  localparam step_t ST_READ_KW  = 4'd12;
  localparam step_t ST_SCAN     = 4'd13;
  localparam step_t ST_EMIT_LTR = 4'd14;
  localparam step_t ST_EMIT_BYT = 4'd15;

  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
    case (s)
      ST_IDLE:     w = '{op: OP_NOP,         cond: C_NSTART,     target: ST_IDLE};
      ST_DIS_CLR:  w = '{op: OP_NOP,         cond: C_CMD_CLEAR,  target: ST_CLEAR};
      ST_DIS_KEY:  w = '{op: OP_NOP,         cond: C_CMD_KEY,    target: ST_APPEND};
      ST_DIS_ENC:  w = '{op: OP_NOP,         cond: C_CMD_ENCODE, target: ST_LOAD_D};
      ST_DROP:     w = '{op: OP_NOP,         cond: C_ALWAYS,     target: ST_IDLE};
      ST_CLEAR:    w = '{op: OP_CLEAR,       cond: C_ALWAYS,     target: ST_IDLE};
      ST_APPEND:   w = '{op: OP_APPEND,      cond: C_ALWAYS,     target: ST_IDLE};
      ST_LOAD_D:   w = '{op: OP_LOAD_D,      cond: C_NEXT,       target: ST_IDLE};
      ST_REDUCE_D: w = '{op: OP_REDUCE_D,    cond: C_D_GE,       target: ST_REDUCE_D};
      ST_CHK_LTR:  w = '{op: OP_NOP,         cond: C_NOT_LETTER, target: ST_EMIT_BYT};
      ST_CALC_K:   w = '{op: OP_CALC_K,      cond: C_NEXT,       target: ST_IDLE};
      ST_SET_M:    w = '{op: OP_SET_M,       cond: C_K_GE,       target: ST_SCAN};
      ST_READ_KW:  w = '{op: OP_READ_KW,     cond: C_ALWAYS,     target: ST_EMIT_LTR};
      ST_SCAN:     w = '{op: OP_SCAN,        cond: C_NOT_FOUND,  target: ST_SCAN};
      ST_EMIT_LTR: w = '{op: OP_EMIT_LETTER, cond: C_ALWAYS,     target: ST_IDLE};
      ST_EMIT_BYT: w = '{op: OP_EMIT_BYTE,   cond: C_ALWAYS,     target: ST_IDLE};
      default:     w = '{op: OP_NOP,         cond: C_ALWAYS,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/keyword_shift_substitution.sv */
// Keyword substitution cipher driven by a small microcode program. An item is taken
// when start is high and busy is low; busy then stays high until the item is done.
// Clear, key and unused-command items pass through the dispatch steps to their
// own step and return to idle. An encode item first reduces the distance register
// by ALPHABET_SIZE, one step for each time it is at or above ALPHABET_SIZE. A byte
// that is not a letter is then passed through as it is. A letter whose cipher
// entry lies in the keyword is read from the keyword table, and one that falls
// among the unused letters is found by scanning the used-letter mask one letter
// per cycle from the first letter, up to the letter that it maps to. The encoded
// byte appears on cipher_byte with cipher_valid high for exactly one cycle, the
// first cycle in which busy is low again; the receiver cannot stall it, so it must
// take every item as it comes.
module keyword_shift_substitution
  import kss_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [7:0]        key_letter,
  input  logic [7:0]        text_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data,
  output logic              cipher_valid,
  output logic [7:0]        cipher_byte
);

  localparam int LW   = $clog2(ALPHABET_SIZE);
  localparam int CW   = $clog2(ALPHABET_SIZE + 1);
  localparam int SUMW = $clog2(2 * ALPHABET_SIZE);
  localparam int CMPW = (DIST_W > CW) ? DIST_W + 1 : CW + 1;

  step_t       pc;
  step_t       pc_next;
  ctrl_word_t  ctrl;
  logic        jump;

  logic [DIST_W-1:0]        shift_distance;
  logic [1:0]               cmd;
  logic [7:0]               key_in;
  logic [7:0]               text_in;
  logic [DIST_W-1:0]        distance;
  logic [LW-1:0]            k;
  logic [LW-1:0]            m;
  logic [LW-1:0]            scan_idx;
  logic [LW-1:0]            li;
  logic [CW-1:0]            keyword_length;
  logic [ALPHABET_SIZE-1:0] letter_used_mask;
  logic [LW-1:0]            keyword_letters [ALPHABET_SIZE];

  logic          accept;
  logic          dist_ge;
  logic          text_is_letter;
  logic          key_is_letter;
  logic [LW-1:0] text_idx;
  logic [LW-1:0] key_idx;
  logic [SUMW-1:0] k_sum;
  logic [LW-1:0] k_calc;
  logic          k_ge_len;
  logic          cur_unused;
  logic          found;
  logic          can_append;

  assign busy      = (pc != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign ctrl      = ucode(pc);

  assign dist_ge        = CMPW'(distance) >= CMPW'(ALPHABET_SIZE);
  assign text_is_letter = (9'(text_in) >= 9'(FIRST_LETTER)) &&
                          (9'(text_in) < 9'(FIRST_LETTER) + 9'(ALPHABET_SIZE));
  assign key_is_letter  = (9'(key_in) >= 9'(FIRST_LETTER)) &&
                          (9'(key_in) < 9'(FIRST_LETTER) + 9'(ALPHABET_SIZE));
  assign text_idx       = LW'(text_in - FIRST_LETTER);
  assign key_idx        = LW'(key_in - FIRST_LETTER);

  assign k_sum  = SUMW'(text_idx) + SUMW'(ALPHABET_SIZE) - SUMW'(distance);
  assign k_calc = (k_sum >= SUMW'(ALPHABET_SIZE)) ? LW'(k_sum - SUMW'(ALPHABET_SIZE))
                                                   : LW'(k_sum);
  assign k_ge_len = CMPW'(k) >= CMPW'(keyword_length);

  assign cur_unused = !letter_used_mask[scan_idx];
  assign found      = cur_unused && (m == '0);
  assign can_append = key_is_letter && !letter_used_mask[key_idx] &&
                      (CMPW'(keyword_length) < CMPW'(ALPHABET_SIZE));

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:       jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NSTART:     jump = !start;
      C_CMD_CLEAR:  jump = (cmd == CMD_CLEAR);
      C_CMD_KEY:    jump = (cmd == CMD_KEY);
      C_CMD_ENCODE: jump = (cmd == CMD_ENCODE);
      C_D_GE:       jump = dist_ge;
      C_NOT_LETTER: jump = !text_is_letter;
      C_K_GE:       jump = k_ge_len;
      C_NOT_FOUND:  jump = !found;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = jump ? ctrl.target : step_t'(pc + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_distance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      shift_distance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= command;
      key_in  <= key_letter;
      text_in <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_length   <= '0;
      letter_used_mask <= '0;
      cipher_valid     <= 1'b0;
    end else begin
      cipher_valid <= (ctrl.op == OP_EMIT_LETTER) || (ctrl.op == OP_EMIT_BYTE);
      if (ctrl.op == OP_CLEAR) begin
        keyword_length   <= '0;
        letter_used_mask <= '0;
      end else if (ctrl.op == OP_APPEND && can_append) begin
        keyword_length            <= keyword_length + CW'(1);
        letter_used_mask[key_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_APPEND && can_append) begin
      keyword_letters[keyword_length[LW-1:0]] <= key_idx;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD_D: distance <= shift_distance;
      OP_REDUCE_D: begin
        if (dist_ge) begin
          distance <= DIST_W'(CMPW'(distance) - CMPW'(ALPHABET_SIZE));
        end
      end
      OP_CALC_K: k <= k_calc;
      OP_SET_M: begin
        m        <= LW'(CMPW'(k) - CMPW'(keyword_length));
        scan_idx <= '0;
      end
      OP_READ_KW: li <= keyword_letters[k];
      OP_SCAN: begin
        if (cur_unused) begin
          if (m == '0) begin
            li <= scan_idx;
          end else begin
            m <= m - LW'(1);
          end
        end
        scan_idx <= scan_idx + LW'(1);
      end
      OP_EMIT_LETTER: cipher_byte <= FIRST_LETTER + 8'(li);
      OP_EMIT_BYTE:   cipher_byte <= text_in;
      default: begin
      end
    endcase
  end

endmodule
